// ===== hdl/h2d_pkg.sv =====
`default_nettype none
package h2d_pkg;

  localparam logic [3:0] HDR_BYTES = 4'd9;
  localparam logic [3:0] HDR_LAST_POS = 4'd8;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic        reserved_bit;
    logic [30:0] stream_id;
    logic [7:0]  payload_byte;
    logic        frame_last;
  } out_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic [3:0] pos;
    logic       store;
    logic       emit;
    logic [1:0] kind;
    logic       with_hdr;
    logic       keep_byte;
    logic       last;
  } op_t;

endpackage
`default_nettype wire

// ===== hdl/h2d_front.sv =====
`default_nettype none
module h2d_front
  import h2d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire in_item_t item,
  output op_t           op
);

  logic [3:0]  hpos;
  logic [3:0]  hpos_next;
  logic        in_pay;
  logic        in_pay_next;
  logic [23:0] len;
  logic [23:0] len_next;
  logic [23:0] rem;
  logic [23:0] rem_next;
  logic [3:0]  pos;
  logic [23:0] rem_dec;

  assign pos = (hpos >= HDR_BYTES) ? 4'd0 : hpos;
  assign rem_dec = rem - 24'd1;

  always_comb begin
    hpos_next = hpos;
    in_pay_next = in_pay;
    len_next = len;
    rem_next = rem;
    op = '0;
    op.data = item.stream_byte;
    op.pos = pos;
    if (in_pay) begin
      op.emit = 1'b1;
      op.with_hdr = 1'b1;
      op.keep_byte = 1'b1;
      rem_next = rem_dec;
      priority if (rem_dec == 24'd0) begin
        op.kind = KIND_PAYLOAD;
        op.last = 1'b1;
        in_pay_next = 1'b0;
        hpos_next = 4'd0;
      end else if (item.buffer_end) begin
        op.kind = KIND_TRUNC;
        op.last = 1'b1;
        in_pay_next = 1'b0;
        hpos_next = 4'd0;
        rem_next = 24'd0;
      end else begin
        op.kind = KIND_PAYLOAD;
      end
    end else begin
      op.store = 1'b1;
      unique case (pos)
        4'd0: len_next = {item.stream_byte, 16'd0};
        4'd1: len_next = {len[23:16], item.stream_byte, 8'd0};
        4'd2: len_next = {len[23:8], item.stream_byte};
        default: len_next = len;
      endcase
      if (pos != HDR_LAST_POS) begin
        hpos_next = pos + 4'd1;
        if (item.buffer_end) begin
          op.emit = 1'b1;
          op.kind = KIND_TRUNC;
          op.last = 1'b1;
          hpos_next = 4'd0;
        end
      end else begin
        op.emit = 1'b1;
        op.with_hdr = 1'b1;
        hpos_next = 4'd0;
        priority if (len == 24'd0) begin
          op.kind = KIND_HEADER;
          op.last = 1'b1;
        end else if (item.buffer_end) begin
          op.kind = KIND_TRUNC;
          op.last = 1'b1;
        end else begin
          op.kind = KIND_HEADER;
          in_pay_next = 1'b1;
          rem_next = len;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hpos <= 4'd0;
      in_pay <= 1'b0;
      len <= 24'd0;
      rem <= 24'd0;
    end else if (take) begin
      hpos <= hpos_next;
      in_pay <= in_pay_next;
      len <= len_next;
      rem <= rem_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/h2d_fifo.sv =====
`default_nettype none
module h2d_fifo
  import h2d_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire op_t  wdata,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output op_t       head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  op_t           mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head = mem[rptr];
  assign do_push = push && !full;
  assign do_pop = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST_IDX) ? '0 : wptr + AW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == LAST_IDX) ? '0 : rptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/h2d_back.sv =====
`default_nettype none
module h2d_back
  import h2d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire op_t   head,
  output logic       pop,
  output logic       result_valid,
  input  wire logic  result_stall,
  output out_item_t  result_data
);

  logic [23:0] len_r;
  logic [23:0] len_next;
  logic [7:0]  type_r;
  logic [7:0]  type_next;
  logic [7:0]  flags_r;
  logic [7:0]  flags_next;
  logic        rsv_r;
  logic        rsv_next;
  logic [30:0] sid_r;
  logic [30:0] sid_next;
  logic        can_load;
  logic        load;
  out_item_t   res;

  always_comb begin
    len_next = len_r;
    type_next = type_r;
    flags_next = flags_r;
    rsv_next = rsv_r;
    sid_next = sid_r;
    if (head.store) begin
      unique case (head.pos)
        4'd0: len_next = {head.data, 16'd0};
        4'd1: len_next = {len_r[23:16], head.data, 8'd0};
        4'd2: len_next = {len_r[23:8], head.data};
        4'd3: type_next = head.data;
        4'd4: flags_next = head.data;
        4'd5: begin
          rsv_next = head.data[7];
          sid_next = {head.data[6:0], 24'd0};
        end
        4'd6: sid_next = {sid_r[30:24], head.data, 16'd0};
        4'd7: sid_next = {sid_r[30:16], head.data, 8'd0};
        4'd8: sid_next = {sid_r[30:8], head.data};
        default: sid_next = sid_r;
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.result_kind = head.kind;
    res.frame_last = head.last;
    res.payload_byte = head.keep_byte ? head.data : 8'd0;
    if (head.with_hdr) begin
      res.frame_length = len_next;
      res.frame_type = type_next;
      res.frame_flags = flags_next;
      res.reserved_bit = rsv_next;
      res.stream_id = sid_next;
    end
  end

  assign can_load = !result_valid || !result_stall;
  assign pop = head_valid && (!head.emit || can_load);
  assign load = pop && head.emit;

  always_ff @(posedge clk) begin
    if (pop) begin
      len_r <= len_next;
      type_r <= type_next;
      flags_r <= flags_next;
      rsv_r <= rsv_next;
      sid_r <= sid_next;
    end
    if (load) begin
      result_data <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/http2_frame_deframer.sv =====
// HTTP/2 frame deframer. Raw bytes enter on the byte channel, one per transfer,
// with buffer_end marking the last byte of a receive buffer. Results leave on
// the result channel: one header result per frame once its ninth header byte
// is in, then one result per payload byte, the final one marked last. A buffer
// that ends inside a frame yields a truncated result and parsing restarts at a
// header. Header bytes other than the ninth give no result unless a buffer ends.
// The front end tracks the header position and payload count and classifies
// each byte; a queue of QUEUE_DEPTH entries feeds the back end, which holds the
// header fields and the output register.
// One byte is taken every cycle unless byte_stall is high, and at most one
// result leaves every cycle. An accepted byte is written into the queue; its
// result is registered in the output register once it reaches the queue head.
// When result_stall is high the result holds; the queue holds up to QUEUE_DEPTH
// bytes and byte_stall rises when it is full. Reset clears the parse state, the
// queue and the result valid, after which a new frame header is expected.
`default_nettype none
module http2_frame_deframer
  import h2d_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     byte_valid,
  output logic          byte_stall,
  input  wire in_item_t byte_data,
  output logic          result_valid,
  input  wire logic     result_stall,
  output out_item_t     result_data
);

  op_t  front_op;
  op_t  head;
  logic full;
  logic take;
  logic head_valid;
  logic pop;

  assign byte_stall = full;
  assign take = byte_valid && !full;

  h2d_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (byte_data),
    .op   (front_op)
  );

  h2d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (take),
    .wdata      (front_op),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  h2d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.result_kind == KIND_TRUNC |-> result_data.frame_last)
    else $error("Truncated result without last mark.");

  a_header_no_byte: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.result_kind == KIND_HEADER |->
      result_data.payload_byte == 8'd0)
    else $error("Header result carries a payload byte.");

  a_empty_frame_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.result_kind == KIND_HEADER &&
      result_data.frame_length == 24'd0 |-> result_data.frame_last)
    else $error("Empty frame header not marked last.");

  a_pop_has_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("Queue popped while empty.");

endmodule
`default_nettype wire
